>>> hw/rtl/lr4_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the fourth-order crossover section.
// No dependencies; imported by lr4_cascaded_biquad_filter.
package lr4_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 32;

  // Coefficient register file
  localparam int NUM_GAINS  = 5;
  localparam int CFG_ADDR_W = 3;

  // Register indexes; also the order of the terms in the stage sum
  localparam logic [CFG_ADDR_W-1:0] IDX_FF0 = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] IDX_FF1 = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] IDX_FF2 = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] IDX_FB1 = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] IDX_FB2 = 3'd4;

endpackage

>>> hw/rtl/lr4_cascaded_biquad_filter.sv
`timescale 1ns / 1ps
// Bit-serial datapath: the multiply-accumulate takes one sample bit of all five
// taps per cycle and runs twice per item, once per biquad. A new item is
// accepted only once the previous result has moved into the output register.
// Reset (rst_n, synchronous, active low): coefficients, sample history and
// handshake state all clear to zero.
module lr4_cascaded_biquad_filter #(
  parameter int SAMPLE_WIDTH = lr4_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = lr4_pkg::COEF_WIDTH_DEF,
  parameter int DATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream; tdata: [SAMPLE_WIDTH-1:0] in_sample, zero padded above
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [DATA_W-1:0]               in_tdata,
  // result stream; tdata: [SAMPLE_WIDTH-1:0] out_sample, zero padded above
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [DATA_W-1:0]               out_tdata,
  // coefficient write port
  input  logic                            cfg_we,
  input  logic [lr4_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [COEF_WIDTH-1:0]           cfg_wdata
);
  import lr4_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CW     = COEF_WIDTH;
  // Partial sum: 5 products of CW x 1 bits plus negation headroom
  localparam int ACC_W  = CW + 4;
  localparam int FULL_W = ACC_W + SW;
  localparam int FRAC   = CW - 2;
  localparam int RES_W  = FULL_W - FRAC;
  localparam int CNT_W  = $clog2(SW);

  localparam logic signed [RES_W-1:0] SAT_MAX = {{(RES_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MIN = {{(RES_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic [FULL_W-1:0]       RND     = FULL_W'(1) << (FRAC - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC1,
    ST_FIN1,
    ST_MAC2,
    ST_FIN2
  } state_t;

  state_t state_r;

  // Coefficients, indexed by register index
  logic signed [CW-1:0] gain_r [NUM_GAINS];

  // Sample history; stage 1 output doubles as stage 2 input history
  logic signed [SW-1:0] in_prev1_r, in_prev2_r;
  logic signed [SW-1:0] mid_prev1_r, mid_prev2_r;
  logic signed [SW-1:0] out_prev1_r, out_prev2_r;

  // Tap operands, shifted out LSB first, one per coefficient
  logic [SW-1:0] tap_sh_r [NUM_GAINS];

  // Shift-add datapath: high partial sum and the bits shifted out below it
  logic signed [ACC_W-1:0] psum_r;
  logic [SW-1:0]           lsum_r;
  logic [CNT_W-1:0]        bit_cnt_r;

  logic                    out_tvalid_r;
  logic [SW-1:0]           out_sample_r;

  // ---------------------------------------------------------------------
  // Bit-serial multiply-accumulate step.
  // Each tap contributes its coefficient when the current sample bit is set;
  // feedback taps contribute the negated coefficient. The sample MSB carries
  // weight -2^(SW-1), so on the last step the selected sum is subtracted.
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0] term [NUM_GAINS];
  logic signed [ACC_W-1:0] tap_sum;
  logic signed [ACC_W-1:0] step_sum;
  logic signed [ACC_W-1:0] psum_nxt;
  logic [SW-1:0]           lsum_nxt;
  logic                    last_bit;

  always_comb begin
    logic signed [ACC_W-1:0] ext;
    tap_sum = '0;
    for (int k = 0; k < NUM_GAINS; k++) begin
      ext = {{(ACC_W-CW){gain_r[k][CW-1]}}, gain_r[k]};
      if (!tap_sh_r[k][0]) begin
        term[k] = '0;
      end else if (CFG_ADDR_W'(k) >= IDX_FB1) begin
        term[k] = -ext;
      end else begin
        term[k] = ext;
      end
      tap_sum = tap_sum + term[k];
    end
  end

  assign last_bit = (bit_cnt_r == CNT_W'(SW - 1));
  assign step_sum = last_bit ? (psum_r - tap_sum) : (psum_r + tap_sum);
  assign psum_nxt = step_sum >>> 1;
  assign lsum_nxt = {step_sum[0], lsum_r[SW-1:1]};

  // ---------------------------------------------------------------------
  // Stage finish: round to nearest (ties up), drop the fraction, saturate.
  // ---------------------------------------------------------------------
  logic signed [FULL_W-1:0] full_sum;
  logic signed [FULL_W-1:0] rnd_sum;
  logic signed [RES_W-1:0]  stage_q;
  logic signed [SW-1:0]     stage_y;

  assign full_sum = {psum_r, lsum_r};
  assign rnd_sum  = full_sum + $signed(RND);
  assign stage_q  = rnd_sum[FULL_W-1:FRAC];

  always_comb begin
    if (stage_q > SAT_MAX) begin
      stage_y = SAT_MAX[SW-1:0];
    end else if (stage_q < SAT_MIN) begin
      stage_y = SAT_MIN[SW-1:0];
    end else begin
      stage_y = stage_q[SW-1:0];
    end
  end

  // Accept only when idle; the output register lets the next item in while
  // a finished result still waits downstream.
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DATA_W'(out_sample_r);

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      in_prev1_r   <= '0;
      in_prev2_r   <= '0;
      mid_prev1_r  <= '0;
      mid_prev2_r  <= '0;
      out_prev1_r  <= '0;
      out_prev2_r  <= '0;
      bit_cnt_r    <= '0;
      for (int k = 0; k < NUM_GAINS; k++) begin
        gain_r[k] <= '0;
      end
    end else begin
      // Coefficient writes; indexes past the last register are dropped
      if (cfg_we && (cfg_addr < CFG_ADDR_W'(NUM_GAINS))) begin
        gain_r[cfg_addr] <= cfg_wdata;
      end

      // Raise the result as stage 2 finishes into a free register; drop it once taken
      if ((state_r == ST_FIN2) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            // Load stage 1 taps, then advance the input history
            tap_sh_r[IDX_FF0] <= in_tdata[SW-1:0];
            tap_sh_r[IDX_FF1] <= in_prev1_r;
            tap_sh_r[IDX_FF2] <= in_prev2_r;
            tap_sh_r[IDX_FB1] <= mid_prev1_r;
            tap_sh_r[IDX_FB2] <= mid_prev2_r;
            in_prev2_r        <= in_prev1_r;
            in_prev1_r        <= in_tdata[SW-1:0];
            psum_r            <= '0;
            bit_cnt_r         <= '0;
            state_r           <= ST_MAC1;
          end
        end

        ST_MAC1, ST_MAC2: begin
          psum_r    <= psum_nxt;
          lsum_r    <= lsum_nxt;
          bit_cnt_r <= last_bit ? '0 : bit_cnt_r + CNT_W'(1);
          for (int k = 0; k < NUM_GAINS; k++) begin
            tap_sh_r[k] <= tap_sh_r[k] >> 1;
          end
          if (last_bit) begin
            state_r <= (state_r == ST_MAC1) ? ST_FIN1 : ST_FIN2;
          end
        end

        ST_FIN1: begin
          // Stage 1 result feeds stage 2; history reads see the old values
          tap_sh_r[IDX_FF0] <= stage_y;
          tap_sh_r[IDX_FF1] <= mid_prev1_r;
          tap_sh_r[IDX_FF2] <= mid_prev2_r;
          tap_sh_r[IDX_FB1] <= out_prev1_r;
          tap_sh_r[IDX_FB2] <= out_prev2_r;
          mid_prev2_r       <= mid_prev1_r;
          mid_prev1_r       <= stage_y;
          psum_r            <= '0;
          state_r           <= ST_MAC2;
        end

        ST_FIN2: begin
          // Hold the finished sum until the output register is free
          if (out_free) begin
            out_sample_r <= stage_y;
            out_prev2_r  <= out_prev1_r;
            out_prev1_r  <= stage_y;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/lr4_checker_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the fourth-order crossover section: a bit-exact predictor of the cascaded biquads
// and the queue of filtered samples still awaited. Depends on lr4_pkg.
package lr4_checker_pkg;

  localparam int SW   = lr4_pkg::SAMPLE_WIDTH_DEF;
  localparam int CW   = lr4_pkg::COEF_WIDTH_DEF;
  localparam int FRAC = CW - 2;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< (SW - 1));
  localparam longint ROUND_HALF = longint'(1) <<< (FRAC - 1);

  class lr4_checker;
    logic signed [CW-1:0] gain [lr4_pkg::NUM_GAINS];
    logic signed [SW-1:0] x_d1, x_d2, m_d1, m_d2, y_d1, y_d2;
    logic signed [SW-1:0] expected_out [$];
    int failures;
    int noted;
    int checked;

    function new();
      foreach (gain[i]) gain[i] = '0;
      x_d1 = '0; x_d2 = '0;
      m_d1 = '0; m_d2 = '0;
      y_d1 = '0; y_d2 = '0;
      failures = 0;
      noted    = 0;
      checked  = 0;
    endfunction

    // Indexes past the last gain are dropped, as in the block.
    function void write_gain(logic [lr4_pkg::CFG_ADDR_W-1:0] idx, logic [CW-1:0] val);
      if (idx < lr4_pkg::NUM_GAINS) gain[idx] = val;
    endfunction

    // One direct-form-I stage: exact sum, round half up, saturate.
    function logic signed [SW-1:0] biquad(logic signed [SW-1:0] x0, logic signed [SW-1:0] x1,
                                          logic signed [SW-1:0] x2, logic signed [SW-1:0] y1,
                                          logic signed [SW-1:0] y2);
      longint acc;
      acc = longint'(gain[lr4_pkg::IDX_FF0]) * longint'(x0)
          + longint'(gain[lr4_pkg::IDX_FF1]) * longint'(x1)
          + longint'(gain[lr4_pkg::IDX_FF2]) * longint'(x2)
          - longint'(gain[lr4_pkg::IDX_FB1]) * longint'(y1)
          - longint'(gain[lr4_pkg::IDX_FB2]) * longint'(y2);
      acc = (acc + ROUND_HALF) >>> FRAC;
      if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
      if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
      return SW'(acc);
    endfunction

    function void note_sample(logic [SW-1:0] raw);
      logic signed [SW-1:0] x, mid, res;
      x   = signed'(raw);
      mid = biquad(x, x_d1, x_d2, m_d1, m_d2);
      res = biquad(mid, m_d1, m_d2, y_d1, y_d2);
      x_d2 = x_d1;  x_d1 = x;
      m_d2 = m_d1;  m_d1 = mid;
      y_d2 = y_d1;  y_d1 = res;
      expected_out.push_back(res);
      noted++;
    endfunction

    function void check_sample(logic [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (expected_out.size() == 0) begin
        $display("%0t: filtered sample %0d arrived with nothing expected",
                 $time, signed'(got));
        failures++;
        return;
      end
      want = expected_out.pop_front();
      checked++;
      if (want !== got) begin
        $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                 $time, want, signed'(got));
        failures++;
      end
    endfunction

    function int pending();
      return expected_out.size();
    endfunction
  endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Top level of the crossover filter testbench: clock, reset, stream drivers and the stimulus plan.
// Depends on lr4_pkg, lr4_checker_pkg and the lr4_cascaded_biquad_filter RTL.
module testbench;
  import lr4_checker_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int SETTLE       = 2 * SW + 12;   // block latency plus margin

  localparam logic [CW-1:0] Q_ONE  = 32'sh4000_0000;   // 1.0 in Q2.30
  localparam logic [CW-1:0] Q_HALF = 32'sh2000_0000;
  localparam logic [CW-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic [CW-1:0] Q_MIN  = 32'sh8000_0000;
  localparam logic [SW-1:0] S_MAX  = 24'h7F_FFFF;
  localparam logic [SW-1:0] S_MIN  = 24'h80_0000;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [SW-1:0]                 in_tdata   = '0;   // [23:0] in_sample
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [SW-1:0]                 out_tdata;          // [23:0] out_sample
  logic                          cfg_we     = 1'b0;
  logic [lr4_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CW-1:0]                 cfg_wdata  = '0;

  lr4_checker sb = new();

  // Stall controls for the two sides; a quiet phase starts no new stalls or gaps.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_stall = 0;
  int rx_roll;
  int settings_used = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lr4_cascaded_biquad_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Observe every handshake at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_gain(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) sb.note_sample(in_tdata);
      if (out_tvalid && out_tready) sb.check_sample(out_tdata);
    end
  end

  // Result side: short stalls now and then, rarely a long one; a quiet phase starts none.
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else begin
      out_tready <= 1'b1;
      if (!rx_quiet) begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 25)      rx_stall <= $urandom_range(1, 3);
        else if (rx_roll < 29) rx_stall <= $urandom_range(20, 120);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d filtered samples still awaited", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // Full-range samples most of the time, with small values and the extremes mixed in.
  function automatic logic [SW-1:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return SW'($urandom);
    if (roll < 85) return SW'($urandom_range(0, 512) - 256);
    case ($urandom_range(0, 3))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // All tasks are entered and left at a falling edge.
  task automatic send_sample(input logic [SW-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  // Hold the input off until every filtered sample has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [lr4_pkg::CFG_ADDR_W-1:0] idx, input logic [CW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // Load a full coefficient set once the block is idle; optionally poke an unused index.
  task automatic load_gains(input logic [CW-1:0] ff0, input logic [CW-1:0] ff1,
                            input logic [CW-1:0] ff2, input logic [CW-1:0] fb1,
                            input logic [CW-1:0] fb2, input bit poke_unused);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    write_reg(lr4_pkg::IDX_FF0, ff0);
    write_reg(lr4_pkg::IDX_FF1, ff1);
    write_reg(lr4_pkg::IDX_FF2, ff2);
    write_reg(lr4_pkg::IDX_FB1, fb1);
    write_reg(lr4_pkg::IDX_FB2, fb2);
    if (poke_unused)
      write_reg(lr4_pkg::CFG_ADDR_W'(lr4_pkg::NUM_GAINS + $urandom_range(0, 2)), $urandom);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int kind;
    int run_len;
    int sent;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Gains still at their reset value of zero: everything filters to silence.
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Unity pass-through: extremes and alternating bit patterns come out unchanged.
    load_gains(Q_ONE, '0, '0, '0, '0, 1'b0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
    send_sample('1);
    send_sample(24'h00_0001);
    send_sample(24'h55_5555);
    send_sample(24'hAA_AAAA);

    // Gain of one half: odd samples land on exact ties, which round upwards.
    load_gains(Q_HALF, '0, '0, '0, '0, 1'b0);
    send_sample(24'h00_0001);
    send_sample('1);
    send_sample(24'h00_0003);
    send_sample(24'hFF_FFFD);

    // Extreme gains with an unused index written too: both stages saturate and the
    // clipped values feed back through the history.
    load_gains(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample('0);
    send_sample(S_MIN);
    send_sample('0);

    // Random phases, each under a fresh coefficient set.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 4);
      case (kind)
        0: load_gains(32'sd4205967, 32'sd8411934, 32'sd4205967,      // 1 kHz low-pass
                      -32'sd1949185008, 32'sd892279456, $urandom_range(0, 2) == 0);
        1: load_gains(32'sd978801572, -32'sd1957603144, 32'sd978801572,  // 1 kHz high-pass
                      -32'sd1949185008, 32'sd892279456, $urandom_range(0, 2) == 0);
        2: load_gains($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 2) == 0);
        3: load_gains(CW'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                      CW'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                      CW'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                      '0, '0, $urandom_range(0, 2) == 0);
        default: load_gains(Q_ONE, '0, '0,
                            CW'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000,
                            CW'($urandom_range(0, 32'h1000_0000)),
                            $urandom_range(0, 2) == 0);
      endcase
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      run_len  = $urandom_range(30, 90);
      repeat (run_len) begin
        send_sample(pick_sample());
        sent++;
        if ($urandom_range(0, 49) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d samples under %0d coefficient sets: pass-through, rounding ties,",
             sb.noted, settings_used + 1);
    $display("saturation in both stages, filter designs and random gains; %0d results checked",
             sb.checked);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
